>>> rtl/core/round_robin_rotation_list_defines.svh
// Assertion macros used by the rotation list top module.
`ifndef ROUND_ROBIN_ROTATION_LIST_DEFINES_SVH
`define ROUND_ROBIN_ROTATION_LIST_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RRRL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RRRL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rrrl_pkg.sv
`default_nettype none

package rrrl_pkg;

  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned PORT_ID_W   = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned TOTAL_W     = 9;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TAIL_INS    = 3'd0,
    ACT_HEAD_INS    = 3'd1,
    ACT_INS_AFTER   = 3'd2,
    ACT_REMOVE      = 3'd3,
    ACT_REMOVE_CUR  = 3'd4,
    ACT_ADVANCE     = 3'd5,
    ACT_FIND        = 3'd6,
    ACT_MOST_ACTIVE = 3'd7
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_ROT  = 3'd1,
    CELL_INS  = 3'd2,
    CELL_DEL  = 3'd3,
    CELL_ADV  = 3'd4
  } cell_op_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_SCAN = 2'd1,
    FSM_EXEC = 2'd2
  } fsm_e;

endpackage

`default_nettype wire

>>> rtl/core/round_robin_rotation_list.sv
// Round-robin rotation list: an ordered ring of up to CAPACITY speakers, each
// with a saturating turn counter, front entry = current turn.
// Input channel s_axis_*: one command item (action, speaker id, reference id).
// Output channel m_axis_*: exactly one result item per command (status,
// result id, position, entry total, current front id, empty flag).
// The entries live in a row of cells that shift to their neighbors.
// Tail/head insert, remove current and advance go straight to the execute
// cycle, which registers the result item; the next item is taken once the
// block is back in idle.
// Insert after, remove, find and most active first rotate the whole ring once
// through the front compare unit, one occupied entry per scan step, then go
// to the execute cycle; the ring ends where it started. A command on an
// empty ring skips the rotation.
// The execute cycle commits only when the output register is empty or being
// taken, so a stalled receiver holds the result and the block waits; no new
// item is accepted until the current one is committed.
// Reset empties the ring (occupancy zero) and drops any pending result; entry
// storage itself is not cleared.
`default_nettype none

module round_robin_rotation_list #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned ID_WIDTH    = 16,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [2:0] action, [18:3] speaker_id, [34:19] reference_id, [39:35] zero
  input  wire [rrrl_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  wire                                  m_axis_tready_i,
  // [1:0] status, [17:2] result_id, [25:18] position, [34:26] entry_total,
  // [50:35] current_id, [51] is_empty, [55:52] zero
  output logic [rrrl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);

  localparam int unsigned IDX_W   = $clog2(CAPACITY);
  localparam int unsigned OCC_W   = $clog2(CAPACITY + 1);
  localparam int unsigned IN_ID_W =
    (ID_WIDTH < rrrl_pkg::PORT_ID_W) ? ID_WIDTH : rrrl_pkg::PORT_ID_W;

  // input unpack
  rrrl_pkg::action_e in_action;
  logic [ID_WIDTH-1:0] in_id, in_ref;

  assign in_action = rrrl_pkg::action_e'(s_axis_tdata_i[2:0]);
  assign in_id     = ID_WIDTH'(s_axis_tdata_i[3 +: IN_ID_W]);
  assign in_ref    = ID_WIDTH'(s_axis_tdata_i[19 +: IN_ID_W]);

  rrrl_pkg::fsm_e      state_d, state_q;
  rrrl_pkg::action_e   act_q;
  logic [ID_WIDTH-1:0] id_q, ref_q;
  logic [OCC_W-1:0]    occ_d, occ_q;
  logic [IDX_W-1:0]    k_d, k_q;
  logic                out_valid_d, out_valid_q;

  logic [rrrl_pkg::STATUS_W-1:0]  out_status_q;
  logic [rrrl_pkg::PORT_ID_W-1:0] out_result_q, out_current_q;
  logic [rrrl_pkg::POS_W-1:0]     out_pos_q;
  logic [rrrl_pkg::TOTAL_W-1:0]   out_total_q;
  logic                           out_empty_q;

  // chain wiring
  logic [ID_WIDTH-1:0]    cell_id  [CAPACITY];
  logic [COUNT_WIDTH-1:0] cell_cnt [CAPACITY];

  rrrl_pkg::cell_op_e  cell_op;
  logic [IDX_W-1:0]    cell_pos;
  logic [IDX_W-1:0]    last_idx;

  // execute-cycle decode
  rrrl_pkg::status_e   exec_status;
  rrrl_pkg::cell_op_e  exec_op;
  logic [IDX_W-1:0]    exec_pos;
  logic [ID_WIDTH-1:0] exec_result;
  logic [IDX_W-1:0]    exec_position;
  logic [ID_WIDTH-1:0] head_next;

  logic                out_free, commit, scan_step, accept, needs_scan;
  logic                is_full, is_empty_now;
  logic                scan_found;
  logic [IDX_W-1:0]    scan_pos;
  logic [ID_WIDTH-1:0] scan_best_id, scan_key;
  logic                occ_step_ok;

  assign out_free     = !out_valid_q || m_axis_tready_i;
  assign accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign is_full      = (occ_q == OCC_W'(CAPACITY));
  assign is_empty_now = (occ_q == '0);
  assign last_idx     = IDX_W'(occ_q - OCC_W'(1));
  assign needs_scan   = (in_action == rrrl_pkg::ACT_INS_AFTER) ||
                        (in_action == rrrl_pkg::ACT_REMOVE) ||
                        (in_action == rrrl_pkg::ACT_FIND) ||
                        (in_action == rrrl_pkg::ACT_MOST_ACTIVE);
  assign scan_key     = (act_q == rrrl_pkg::ACT_INS_AFTER) ? ref_q : id_q;
  assign occ_step_ok  = (occ_d == occ_q) || (occ_d == occ_q + OCC_W'(1)) ||
                        (occ_d + OCC_W'(1) == occ_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrrl_pkg::FSM_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = (needs_scan && !is_empty_now) ? rrrl_pkg::FSM_SCAN
                                                  : rrrl_pkg::FSM_EXEC;
        end
      end
      rrrl_pkg::FSM_SCAN: begin
        if (k_q == last_idx) begin
          state_d = rrrl_pkg::FSM_EXEC;
        end
      end
      rrrl_pkg::FSM_EXEC: begin
        if (out_free) begin
          state_d = rrrl_pkg::FSM_IDLE;
        end
      end
      default: state_d = rrrl_pkg::FSM_IDLE;
    endcase
  end

  // outputs and execute decode
  always_comb begin
    s_axis_tready_o = (state_q == rrrl_pkg::FSM_IDLE);
    scan_step       = (state_q == rrrl_pkg::FSM_SCAN);
    commit          = (state_q == rrrl_pkg::FSM_EXEC) && out_free;

    exec_status   = rrrl_pkg::STAT_OK;
    exec_op       = rrrl_pkg::CELL_HOLD;
    exec_pos      = '0;
    exec_result   = '0;
    exec_position = '0;
    occ_d         = occ_q;

    unique case (act_q) inside
      rrrl_pkg::ACT_TAIL_INS, rrrl_pkg::ACT_HEAD_INS: begin
        if (is_full) begin
          exec_status = rrrl_pkg::STAT_FULL;
        end else begin
          exec_op  = rrrl_pkg::CELL_INS;
          exec_pos = (act_q == rrrl_pkg::ACT_TAIL_INS) ? IDX_W'(occ_q) : '0;
          occ_d    = occ_q + OCC_W'(1);
        end
      end
      default: begin
        if (is_empty_now) begin
          exec_status = rrrl_pkg::STAT_EMPTY;
        end else begin
          unique case (act_q)
            rrrl_pkg::ACT_INS_AFTER: begin
              if (!scan_found) begin
                exec_status = rrrl_pkg::STAT_NOT_FOUND;
              end else if (is_full) begin
                exec_status = rrrl_pkg::STAT_FULL;
              end else begin
                exec_op  = rrrl_pkg::CELL_INS;
                exec_pos = scan_pos + IDX_W'(1);
                occ_d    = occ_q + OCC_W'(1);
              end
            end
            rrrl_pkg::ACT_REMOVE: begin
              if (!scan_found) begin
                exec_status = rrrl_pkg::STAT_NOT_FOUND;
              end else begin
                exec_op  = rrrl_pkg::CELL_DEL;
                exec_pos = scan_pos;
                occ_d    = occ_q - OCC_W'(1);
              end
            end
            rrrl_pkg::ACT_REMOVE_CUR: begin
              exec_op = rrrl_pkg::CELL_DEL;
              occ_d   = occ_q - OCC_W'(1);
            end
            rrrl_pkg::ACT_ADVANCE: begin
              exec_op = rrrl_pkg::CELL_ADV;
            end
            rrrl_pkg::ACT_FIND: begin
              if (!scan_found) begin
                exec_status = rrrl_pkg::STAT_NOT_FOUND;
              end else begin
                exec_position = scan_pos;
              end
            end
            rrrl_pkg::ACT_MOST_ACTIVE: begin
              exec_result = scan_best_id;
            end
            default: ;
          endcase
        end
      end
    endcase

    // front entry once this command lands
    unique case (exec_op)
      rrrl_pkg::CELL_INS: head_next = (exec_pos == '0) ? id_q : cell_id[0];
      rrrl_pkg::CELL_DEL: head_next = (exec_pos == '0) ? cell_id[1] : cell_id[0];
      rrrl_pkg::CELL_ADV: head_next = (occ_q > OCC_W'(1)) ? cell_id[1] : cell_id[0];
      default:            head_next = cell_id[0];
    endcase
    if (exec_op == rrrl_pkg::CELL_ADV) begin
      exec_result = head_next;
    end

    // rotate during the scan, apply the command on commit, else hold
    if (scan_step) begin
      cell_op  = rrrl_pkg::CELL_ROT;
      cell_pos = '0;
    end else if (commit) begin
      cell_op  = exec_op;
      cell_pos = exec_pos;
    end else begin
      cell_op  = rrrl_pkg::CELL_HOLD;
      cell_pos = '0;
    end

    k_d = k_q;
    if (accept) begin
      k_d = '0;
    end else if (scan_step) begin
      k_d = k_q + IDX_W'(1);
    end

    out_valid_d = commit ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrrl_pkg::FSM_IDLE;
      occ_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        occ_q <= occ_d;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= in_action;
      id_q  <= in_id;
      ref_q <= in_ref;
    end
    if (commit) begin
      out_status_q  <= exec_status;
      out_result_q  <= rrrl_pkg::PORT_ID_W'(exec_result);
      out_pos_q     <= rrrl_pkg::POS_W'(exec_position);
      out_total_q   <= rrrl_pkg::TOTAL_W'(occ_d);
      out_current_q <= (occ_d == '0) ? '0 : rrrl_pkg::PORT_ID_W'(head_next);
      out_empty_q   <= (occ_d == '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_empty_q, out_current_q, out_total_q,
                            out_pos_q, out_result_q, out_status_q};

  // row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ID_WIDTH-1:0]    prev_id, next_id;
    logic [COUNT_WIDTH-1:0] prev_cnt, next_cnt;

    if (g == 0) begin : g_first
      assign prev_id  = '0;
      assign prev_cnt = '0;
    end else begin : g_mid_prev
      assign prev_id  = cell_id[g-1];
      assign prev_cnt = cell_cnt[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_id  = '0;
      assign next_cnt = '0;
    end else begin : g_mid_next
      assign next_id  = cell_id[g+1];
      assign next_cnt = cell_cnt[g+1];
    end

    rrrl_cell #(
      .INDEX       (g),
      .ID_WIDTH    (ID_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH),
      .IDX_W       (IDX_W)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op),
      .pos_i       (cell_pos),
      .last_i      (last_idx),
      .new_id_i    (id_q),
      .prev_id_i   (prev_id),
      .prev_cnt_i  (prev_cnt),
      .next_id_i   (next_id),
      .next_cnt_i  (next_cnt),
      .front_id_i  (cell_id[0]),
      .front_cnt_i (cell_cnt[0]),
      .id_o        (cell_id[g]),
      .cnt_o       (cell_cnt[g])
    );
  end

  // front compare unit: sees each entry once per rotation, in order
  rrrl_scan #(
    .ID_WIDTH    (ID_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (scan_step),
    .first_i     (k_q == '0),
    .idx_i       (k_q),
    .key_i       (scan_key),
    .front_id_i  (cell_id[0]),
    .front_cnt_i (cell_cnt[0]),
    .found_o     (scan_found),
    .pos_o       (scan_pos),
    .best_id_o   (scan_best_id)
  );

  `include "round_robin_rotation_list_defines.svh"

  `RRRL_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= OCC_W'(CAPACITY), "occupancy above capacity")
  `RRRL_ASSERT_NXT(a_scan_occ_stable, scan_step, $stable(occ_q), "occupancy moved in scan")
  `RRRL_ASSERT_IMP(a_commit_step, commit, occ_step_ok, "occupancy jumped by more than one")
  `RRRL_ASSERT_IMP(a_result_from_exec, $rose(out_valid_q), $past(commit), "result without commit")

endmodule

`default_nettype wire

>>> rtl/core/rrrl_cell.sv
`default_nettype none

module rrrl_cell #(
  parameter int unsigned INDEX       = 0,
  parameter int unsigned ID_WIDTH    = 16,
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned IDX_W       = 4
) (
  input  wire                     clk_i,
  input  rrrl_pkg::cell_op_e      op_i,
  input  wire [IDX_W-1:0]         pos_i,
  input  wire [IDX_W-1:0]         last_i,
  input  wire [ID_WIDTH-1:0]      new_id_i,
  input  wire [ID_WIDTH-1:0]      prev_id_i,
  input  wire [COUNT_WIDTH-1:0]   prev_cnt_i,
  input  wire [ID_WIDTH-1:0]      next_id_i,
  input  wire [COUNT_WIDTH-1:0]   next_cnt_i,
  input  wire [ID_WIDTH-1:0]      front_id_i,
  input  wire [COUNT_WIDTH-1:0]   front_cnt_i,
  output logic [ID_WIDTH-1:0]     id_o,
  output logic [COUNT_WIDTH-1:0]  cnt_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [ID_WIDTH-1:0]    id_d, id_q;
  logic [COUNT_WIDTH-1:0] cnt_d, cnt_q;

  always_comb begin
    id_d  = id_q;
    cnt_d = cnt_q;
    unique case (op_i) inside
      rrrl_pkg::CELL_ROT, rrrl_pkg::CELL_ADV: begin
        // the front wraps to the last occupied cell, the rest move up one
        if (MY_IDX == last_i) begin
          id_d  = front_id_i;
          cnt_d = front_cnt_i;
        end else if (MY_IDX < last_i) begin
          id_d  = next_id_i;
          cnt_d = next_cnt_i;
        end
        if (op_i == rrrl_pkg::CELL_ADV && MY_IDX == '0) begin
          if (cnt_d != '1) begin
            cnt_d = cnt_d + COUNT_WIDTH'(1);
          end
        end
      end
      rrrl_pkg::CELL_INS: begin
        if (MY_IDX > pos_i) begin
          id_d  = prev_id_i;
          cnt_d = prev_cnt_i;
        end else if (MY_IDX == pos_i) begin
          id_d  = new_id_i;
          cnt_d = '0;
        end
      end
      rrrl_pkg::CELL_DEL: begin
        if (MY_IDX >= pos_i) begin
          id_d  = next_id_i;
          cnt_d = next_cnt_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    cnt_q <= cnt_d;
  end

  assign id_o  = id_q;
  assign cnt_o = cnt_q;

endmodule

`default_nettype wire

>>> rtl/core/rrrl_scan.sv
`default_nettype none

module rrrl_scan #(
  parameter int unsigned ID_WIDTH    = 16,
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned IDX_W       = 4
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    step_i,
  input  wire                    first_i,
  input  wire [IDX_W-1:0]        idx_i,
  input  wire [ID_WIDTH-1:0]     key_i,
  input  wire [ID_WIDTH-1:0]     front_id_i,
  input  wire [COUNT_WIDTH-1:0]  front_cnt_i,
  output logic                   found_o,
  output logic [IDX_W-1:0]       pos_o,
  output logic [ID_WIDTH-1:0]    best_id_o
);

  logic                   found_d, found_q;
  logic [IDX_W-1:0]       pos_d, pos_q;
  logic [ID_WIDTH-1:0]    best_id_d, best_id_q;
  logic [COUNT_WIDTH-1:0] best_cnt_d, best_cnt_q;
  logic                   hit;

  assign hit = (front_id_i == key_i);

  always_comb begin
    found_d    = found_q;
    pos_d      = pos_q;
    best_id_d  = best_id_q;
    best_cnt_d = best_cnt_q;
    if (step_i) begin
      if (first_i) begin
        found_d    = hit;
        pos_d      = idx_i;
        best_id_d  = front_id_i;
        best_cnt_d = front_cnt_i;
      end else begin
        // keep the first match and the first maximum seen from the front
        if (!found_q && hit) begin
          found_d = 1'b1;
          pos_d   = idx_i;
        end
        if (front_cnt_i > best_cnt_q) begin
          best_id_d  = front_id_i;
          best_cnt_d = front_cnt_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    best_id_q  <= best_id_d;
    best_cnt_q <= best_cnt_d;
  end

  assign found_o   = found_q;
  assign pos_o     = pos_q;
  assign best_id_o = best_id_q;

endmodule

`default_nettype wire
